/* rtl/base64_stream_decoder_top_assert.svh */
// assertion macros for the base64 stream decoder
`ifndef BASE64_STREAM_DECODER_TOP_ASSERT_SVH
`define BASE64_STREAM_DECODER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define B64D_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define B64D_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define B64D_ASSERT(lbl, clk, rst_n, prop, msg)
`define B64D_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

/* rtl/b64d_pkg.sv */
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_PAD  = 2'd2,
    ST_BAD_LEN  = 2'd3
  } status_t;

  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] val;
  } map_t;

  typedef struct packed {
    logic [23:0] data;
    status_t     status;
    logic [1:0]  nres;
    logic        eos;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic map_t b64_map(input logic [7:0] c);
    map_t m;
    m.bad = 1'b0;
    m.pad = 1'b0;
    m.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      m.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      m.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      m.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      m.val = 6'd62;
    end else if (c == 8'h2F) begin
      m.val = 6'd63;
    end else if (c == PAD_CHAR) begin
      m.pad = 1'b1;
    end else begin
      m.bad = 1'b1;
    end
    return m;
  endfunction

endpackage

/* rtl/b64d_front.sv */
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  input  qstat_t     qstat,
  output push_t      push
);

  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        disc_r, disc_nxt;
  logic        accept;
  map_t        m;
  logic [23:0] acc_shift;
  logic [1:0]  pad_new;
  logic        fail;
  logic        emit;
  status_t     code;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;
  assign m        = b64_map(in_char_code);
  assign acc_shift = {acc_r[17:0], (m.pad ? 6'd0 : m.val)};
  assign pad_new  = m.pad ? (pad_r + 2'd1) : pad_r;

  // classify the character and advance the group state
  always_comb begin
    pos_nxt  = pos_r;
    acc_nxt  = acc_r;
    pad_nxt  = pad_r;
    disc_nxt = disc_r;
    fail     = 1'b0;
    emit     = 1'b0;
    code     = ST_DATA;
    if (disc_r) begin
      if (in_last_char) begin
        disc_nxt = 1'b0;
        pos_nxt  = 2'd0;
        acc_nxt  = 24'd0;
        pad_nxt  = 2'd0;
      end
    end else if (m.bad) begin
      fail = 1'b1;
      code = ST_BAD_CHAR;
    end else if (m.pad && pos_r < 2'd2) begin
      fail = 1'b1;
      code = ST_BAD_PAD;
    end else if (!m.pad && pad_r != 2'd0) begin
      fail = 1'b1;
      code = ST_BAD_PAD;
    end else if (pos_r != 2'd3) begin
      if (in_last_char) begin
        fail = 1'b1;
        code = ST_BAD_LEN;
      end else begin
        pos_nxt = pos_r + 2'd1;
        acc_nxt = acc_shift;
        pad_nxt = pad_new;
      end
    end else if (pad_new != 2'd0 && !in_last_char) begin
      fail = 1'b1;
      code = ST_BAD_PAD;
    end else begin
      emit    = 1'b1;
      pos_nxt = 2'd0;
      acc_nxt = 24'd0;
      pad_nxt = 2'd0;
    end
    if (fail) begin
      pos_nxt  = 2'd0;
      acc_nxt  = 24'd0;
      pad_nxt  = 2'd0;
      disc_nxt = !in_last_char;
    end
  end

  always_comb begin
    push.valid      = accept && (fail || emit);
    push.job.status = code;
    if (emit) begin
      push.job.data = acc_shift;
      push.job.nres = 2'd3 - pad_new;
      push.job.eos  = in_last_char;
    end else begin
      push.job.data = 24'd0;
      push.job.nres = 2'd1;
      push.job.eos  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 2'd0;
      acc_r  <= 24'd0;
      pad_r  <= 2'd0;
      disc_r <= 1'b0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      pad_r  <= pad_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

/* rtl/b64d_queue.sv */
`include "base64_stream_decoder_top_assert.svh"

module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  push,
  input  logic   pop,
  output job_t   head,
  output qstat_t qstat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign qstat.full  = (count_r == FULL_CNT);
  assign qstat.empty = (count_r == '0);
  assign head        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push.valid && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push.valid) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

  `B64D_ASSERT(a_no_push_full, clk, rst_n, push.valid |-> !qstat.full, "push into full queue")
  `B64D_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> !qstat.empty, "pop from empty queue")
  `B64D_ASSERT(a_count_range, clk, rst_n, count_r <= FULL_CNT, "queue count out of range")

endmodule

/* rtl/b64d_back.sv */
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  qstat_t     qstat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic [1:0] out_status,
  output logic       out_last_of_item,
  output logic       out_end_of_string
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  status_t    status_r;
  logic       last_r;
  logic       eos_r;
  logic       load;
  logic       fin;
  logic [7:0] sel_byte;

  assign load = !qstat.empty && (!valid_r || !out_stall);
  assign fin  = (idx_r == head.nres - 2'd1);
  assign pop  = load && fin;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head.data[23:16];
      2'd1:    sel_byte = head.data[15:8];
      default: sel_byte = head.data[7:0];
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r && out_stall;
    if (load) begin
      idx_nxt   = fin ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= sel_byte;
      status_r <= head.status;
      last_r   <= fin;
      eos_r    <= fin && head.eos;
    end
  end

  assign out_valid         = valid_r;
  assign out_out_byte      = byte_r;
  assign out_status        = status_r;
  assign out_last_of_item  = last_r;
  assign out_end_of_string = eos_r;

endmodule

/* rtl/base64_stream_decoder_top.sv */
// base64 stream decoder
// input channel: one character per transfer (in_char_code) with in_last_char
// set on the final character of a string; in_valid / in_stall handshake
// result channel: one decoded byte or one error code per transfer; status 0
// is data, 1 bad character, 2 misplaced padding, 3 bad length
// out_last_of_item marks the final result of one decoded group or error and
// out_end_of_string the result that closes a string; after an error the rest
// of the string is dropped up to its last character, and bytes already sent
// for that string should be thrown away by the receiver
// a character is taken every cycle while the job queue has room; a complete
// group gives up to three byte transfers, one per cycle from the output
// register while out_stall is low, so the output port sets the sustained rate
// a result is written into the job queue and then into the output register
// when out_stall is high a valid output register holds and the queue fills;
// in_stall rises once all QUEUE_DEPTH entries are in use
// synchronous active low reset clears the group state, queue and output valid
module base64_stream_decoder_top
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic [1:0] out_status,
  output logic       out_last_of_item,
  output logic       out_end_of_string
);

  push_t  push;
  qstat_t qstat;
  job_t   head;
  logic   pop;

  b64d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .qstat        (qstat),
    .push         (push)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  b64d_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .qstat             (qstat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_out_byte      (out_out_byte),
    .out_status        (out_status),
    .out_last_of_item  (out_last_of_item),
    .out_end_of_string (out_end_of_string)
  );

endmodule
